FILE: src/arithmetic_expression_tokenizer_top_assert.svh
// assertion macros for the tokenizer, clocked on clk and quiet during reset
`ifndef ARITHMETIC_EXPRESSION_TOKENIZER_TOP_ASSERT_SVH
`define ARITHMETIC_EXPRESSION_TOKENIZER_TOP_ASSERT_SVH

// plain property checked at every edge out of reset
`define AET_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define AET_ASSERT_IMP(label, ante, cons, msg) \
	`AET_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define AET_ASSERT_NEXT(label, ante, cons, msg) \
	`AET_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: src/aet_pkg.sv
// types, character codes and class decode for the expression tokenizer
package aet_pkg;

	localparam int KIND_BITS   = 4;
	localparam int LEN_BITS    = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int CNT_BITS    = 3;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_END     = 4'd0,
		KIND_IDENT   = 4'd1,
		KIND_INT     = 4'd2,
		KIND_FLOAT   = 4'd3,
		KIND_PLUS    = 4'd4,
		KIND_MINUS   = 4'd5,
		KIND_STAR    = 4'd6,
		KIND_SLASH   = 4'd7,
		KIND_EQUALS  = 4'd8,
		KIND_LPAREN  = 4'd9,
		KIND_RPAREN  = 4'd10,
		KIND_SEMI    = 4'd11,
		KIND_UNKNOWN = 4'd12
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_IDENT = 2'd1,
		MODE_INT   = 2'd2,
		MODE_FLOAT = 2'd3
	} mode_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	// space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		unique case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_STAR;
			CH_SLASH:  k = KIND_SLASH;
			CH_EQUALS: k = KIND_EQUALS;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_SEMI:   k = KIND_SEMI;
			default:   k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

FILE: src/arithmetic_expression_tokenizer_top.sv
// A token enters the token queue when the byte that closes it is accepted.
// Throughput: one byte per cycle while the queue has room; a byte can yield two tokens.
// The four-entry token queue takes a byte while it has room for two tokens.
// Reset (async, active low): scanner idle at line 1, column 1, offset 0; queue empty.
// A byte 0 emits the end token and returns the position to line 1, column 1, offset 0.
`include "arithmetic_expression_tokenizer_top_assert.svh"

module arithmetic_expression_tokenizer_top
	import aet_pkg::*;
#(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             text_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [KIND_BITS-1:0]   token_kind,
	output logic [LINE_BITS-1:0]   token_line,
	output logic [COLUMN_BITS-1:0] token_column,
	output logic [OFFSET_BITS-1:0] token_offset,
	output logic [LEN_BITS-1:0]    token_length,
	output logic                   last_of_run
);

	// scanner state
	mode_t                  mode_q, mode_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [COLUMN_BITS-1:0] pcol_q, pcol_d;
	logic [OFFSET_BITS-1:0] poff_q, poff_d;
	logic [LEN_BITS-1:0]    plen_q, plen_d;

	// token queue
	kind_t                  q_kind_q [QUEUE_DEPTH];
	logic [LINE_BITS-1:0]   q_line_q [QUEUE_DEPTH];
	logic [COLUMN_BITS-1:0] q_col_q  [QUEUE_DEPTH];
	logic [OFFSET_BITS-1:0] q_off_q  [QUEUE_DEPTH];
	logic [LEN_BITS-1:0]    q_len_q  [QUEUE_DEPTH];
	logic                   q_last_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q, wr_slot_new;
	logic [CNT_BITS-1:0]    count_q;

	logic                   accept, pop, extend;
	logic                   has_pend, has_new;
	logic [1:0]             n_push;
	kind_t                  pend_kind, new_kind;
	logic [LEN_BITS-1:0]    new_len;
	logic [LINE_BITS-1:0]   line_adv;
	logic [COLUMN_BITS-1:0] col_adv;
	logic [OFFSET_BITS-1:0] off_adv;

	assign in_ready = count_q <= CNT_BITS'(QUEUE_DEPTH - 2);
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	// position after this byte, saturating
	always_comb begin
		off_adv  = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
		line_adv = line_q;
		col_adv  = (col_q == '1) ? col_q : col_q + COLUMN_BITS'(1);
		if (text_byte == CH_NL) begin
			line_adv = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
			col_adv  = COLUMN_BITS'(1);
		end
	end

	// scan mode, position and pending token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= LINE_BITS'(1);
			col_q  <= COLUMN_BITS'(1);
			off_q  <= '0;
			pcol_q <= '0;
			poff_q <= '0;
			plen_q <= '0;
		end else begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
			off_q  <= off_d;
			pcol_q <= pcol_d;
			poff_q <= poff_d;
			plen_q <= plen_d;
		end
	end

	// next scan state and tokens produced by this request
	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		col_d    = col_q;
		off_d    = off_q;
		pcol_d   = pcol_q;
		poff_d   = poff_q;
		plen_d   = plen_q;
		has_pend = 1'b0;
		has_new  = 1'b0;
		new_kind = KIND_END;
		new_len  = '0;

		unique case (mode_q)
			MODE_IDLE:  begin
				extend    = 1'b0;
				pend_kind = KIND_END;
			end
			MODE_IDENT: begin
				extend    = is_letter(text_byte) || is_digit(text_byte) ||
					(text_byte == CH_UNDER);
				pend_kind = KIND_IDENT;
			end
			MODE_INT:   begin
				extend    = is_digit(text_byte) || (text_byte == CH_DOT);
				pend_kind = KIND_INT;
			end
			MODE_FLOAT: begin
				extend    = is_digit(text_byte);
				pend_kind = KIND_FLOAT;
			end
			default:    begin
				extend    = 1'b0;
				pend_kind = KIND_END;
			end
		endcase

		if (accept) begin
			if (extend) begin
				plen_d = (plen_q == '1) ? plen_q : plen_q + LEN_BITS'(1);
				line_d = line_adv;
				col_d  = col_adv;
				off_d  = off_adv;
				if ((mode_q == MODE_INT) && (text_byte == CH_DOT)) begin
					mode_d = MODE_FLOAT;
				end
			end else begin
				// close any pending token
				has_pend = (mode_q != MODE_IDLE);
				mode_d   = MODE_IDLE;
				plen_d   = '0;
				if (text_byte == CH_NUL) begin
					has_new  = 1'b1;
					new_kind = KIND_END;
					new_len  = '0;
					line_d   = LINE_BITS'(1);
					col_d    = COLUMN_BITS'(1);
					off_d    = '0;
				end else if (is_space(text_byte)) begin
					line_d = line_adv;
					col_d  = col_adv;
					off_d  = off_adv;
				end else if (is_letter(text_byte) || (text_byte == CH_UNDER) ||
						is_digit(text_byte)) begin
					mode_d = is_digit(text_byte) ? MODE_INT : MODE_IDENT;
					pcol_d = col_q;
					poff_d = off_q;
					plen_d = LEN_BITS'(1);
					line_d = line_adv;
					col_d  = col_adv;
					off_d  = off_adv;
				end else begin
					has_new  = 1'b1;
					new_kind = punct_kind(text_byte);
					new_len  = LEN_BITS'(1);
					line_d   = line_adv;
					col_d    = col_adv;
					off_d    = off_adv;
				end
			end
		end
	end

	assign n_push      = {1'b0, has_pend} + {1'b0, has_new};
	assign wr_slot_new = wr_ptr_q + QPTR_BITS'(has_pend);

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(n_push);
			rd_ptr_q <= rd_ptr_q + QPTR_BITS'(pop);
			count_q  <= count_q + CNT_BITS'(n_push) - CNT_BITS'(pop);
		end
	end

	// queue entries: pending token first, then the byte's own token
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (has_pend && (wr_ptr_q == QPTR_BITS'(i))) begin
				q_kind_q[i] <= pend_kind;
				q_line_q[i] <= line_q;
				q_col_q[i]  <= pcol_q;
				q_off_q[i]  <= poff_q;
				q_len_q[i]  <= plen_q;
				q_last_q[i] <= !has_new;
			end else if (has_new && (wr_slot_new == QPTR_BITS'(i))) begin
				q_kind_q[i] <= new_kind;
				q_line_q[i] <= line_q;
				q_col_q[i]  <= col_q;
				q_off_q[i]  <= off_q;
				q_len_q[i]  <= new_len;
				q_last_q[i] <= 1'b1;
			end
		end
	end

	// head of queue drives the result port
	assign out_valid    = count_q != '0;
	assign token_kind   = q_kind_q[rd_ptr_q];
	assign token_line   = q_line_q[rd_ptr_q];
	assign token_column = q_col_q[rd_ptr_q];
	assign token_offset = q_off_q[rd_ptr_q];
	assign token_length = q_len_q[rd_ptr_q];
	assign last_of_run  = q_last_q[rd_ptr_q];

	// checks
	`AET_ASSERT(a_queue_bound, count_q <= CNT_BITS'(QUEUE_DEPTH), "token queue overfilled")
	`AET_ASSERT(a_pend_len, (mode_q == MODE_IDLE) == (plen_q == '0), "pending length out of step")
	`AET_ASSERT_NEXT(a_end_clears, accept && (text_byte == CH_NUL), (line_q == LINE_BITS'(1)) && (col_q == COLUMN_BITS'(1)) && (off_q == '0) && (mode_q == MODE_IDLE), "end of text did not clear position")
	`AET_ASSERT_NEXT(a_offset_moves, accept && (text_byte != CH_NUL), off_q != '0, "offset not advanced")

endmodule

FILE: bench/arithmetic_expression_tokenizer_checker.sv
// token predictor and compare logic for the expression tokenizer bench
`timescale 1ns / 100ps

module arithmetic_expression_tokenizer_checker
	import aet_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           text_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [KIND_BITS-1:0] token_kind,
	input  logic [15:0]          token_line,
	input  logic [15:0]          token_column,
	input  logic [19:0]          token_offset,
	input  logic [LEN_BITS-1:0]  token_length,
	input  logic                 last_of_run,
	output int                   failures,
	output int                   outstanding
);
	localparam int PRINT_LIMIT = 200;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line_no;
		logic [15:0] column_no;
		logic [19:0] start_offset;
		logic [15:0] lexeme_len;
		logic        run_end;
	} token_t;

	token_t expected_tokens[$];
	token_t want;

	// scanner position and the token being collected
	mode_t       scan_state;
	logic [15:0] line_now;
	logic [15:0] column_now;
	logic [19:0] offset_now;
	logic [15:0] held_column;
	logic [19:0] held_offset;
	logic [15:0] held_len;

	initial failures = 0;

	task automatic report_mismatch(input string msg);
		failures++;
		// keep the log readable when the block is badly off
		if (failures <= PRINT_LIMIT)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is %0h, should be %0h", name, got, exp_val));
	endtask

	function automatic bit is_num_char(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic bit is_word_start(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
	endfunction

	task automatic push_token(input kind_t k, input logic [15:0] col,
			input logic [19:0] off, input logic [15:0] len);
		token_t tok;
		tok.kind         = k;
		tok.line_no      = line_now;
		tok.column_no    = col;
		tok.start_offset = off;
		tok.lexeme_len   = len;
		tok.run_end      = 1'b0;
		expected_tokens.insert(expected_tokens.size(), tok);
	endtask

	// saturating position advance over one byte
	task automatic step_position(input logic [7:0] c);
		if (offset_now != '1)
			offset_now = offset_now + 1'b1;
		if (c == CH_NL) begin
			if (line_now != '1)
				line_now = line_now + 1'b1;
			column_now = 16'd1;
		end else if (column_now != '1) begin
			column_now = column_now + 1'b1;
		end
	endtask

	// expected tokens for one accepted request
	task automatic predict_tokens(input logic [7:0] c);
		int    before_count;
		bit    grows;
		kind_t sym_kind;
		before_count = expected_tokens.size();
		grows = 1'b0;
		case (scan_state)
			MODE_IDENT: grows = is_word_start(c) || is_num_char(c);
			MODE_INT: begin
				if (c == CH_DOT) begin
					scan_state = MODE_FLOAT;
					grows = 1'b1;
				end else begin
					grows = is_num_char(c);
				end
			end
			MODE_FLOAT: grows = is_num_char(c);
			default: grows = 1'b0;
		endcase

		if (grows) begin
			if (held_len != '1)
				held_len = held_len + 1'b1;
			step_position(c);
		end else begin
			// close the held token first
			if (scan_state != MODE_IDLE) begin
				push_token(scan_state == MODE_IDENT ? KIND_IDENT :
					scan_state == MODE_INT ? KIND_INT : KIND_FLOAT,
					held_column, held_offset, held_len);
				scan_state = MODE_IDLE;
				held_len = '0;
			end

			if (c == CH_NUL) begin
				push_token(KIND_END, column_now, offset_now, '0);
				line_now = 16'd1;
				column_now = 16'd1;
				offset_now = '0;
			end else if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
				step_position(c);
			end else if (is_word_start(c) || is_num_char(c)) begin
				scan_state = is_num_char(c) ? MODE_INT : MODE_IDENT;
				held_column = column_now;
				held_offset = offset_now;
				held_len = 16'd1;
				step_position(c);
			end else begin
				case (c)
					CH_PLUS:   sym_kind = KIND_PLUS;
					CH_MINUS:  sym_kind = KIND_MINUS;
					CH_STAR:   sym_kind = KIND_STAR;
					CH_SLASH:  sym_kind = KIND_SLASH;
					CH_EQUALS: sym_kind = KIND_EQUALS;
					CH_LPAREN: sym_kind = KIND_LPAREN;
					CH_RPAREN: sym_kind = KIND_RPAREN;
					CH_SEMI:   sym_kind = KIND_SEMI;
					default:   sym_kind = KIND_UNKNOWN;
				endcase
				push_token(sym_kind, column_now, offset_now, 16'd1);
				step_position(c);
			end

			// flag the last token this byte produced
			if (expected_tokens.size() > before_count)
				expected_tokens[expected_tokens.size() - 1].run_end = 1'b1;
		end
	endtask

	// predict on each accepted request, compare on each accepted token
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tokens.delete();
			scan_state = MODE_IDLE;
			line_now = 16'd1;
			column_now = 16'd1;
			offset_now = '0;
			held_column = '0;
			held_offset = '0;
			held_len = '0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_tokens(text_byte);
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("token of kind %0d with nothing pending",
						token_kind));
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", token_kind, want.kind);
					check_field("token_line", token_line, want.line_no);
					check_field("token_column", token_column, want.column_no);
					check_field("token_offset", token_offset, want.start_offset);
					check_field("token_length", token_length, want.lexeme_len);
					check_field("last_of_run", last_of_run, want.run_end);
				end
			end
			outstanding <= expected_tokens.size();
		end
	end

endmodule

FILE: bench/arithmetic_expression_tokenizer_top_test.sv
// stimulus, flow control and verdict for the expression tokenizer bench
`timescale 1ns / 100ps

module arithmetic_expression_tokenizer_top_test;
	import aet_pkg::*;

	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_BYTES = 1900;

	localparam logic [7:0] CH_VTAB = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;

	localparam logic [7:0] PUNCT_CHARS [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_EQUALS, CH_LPAREN, CH_RPAREN, CH_SEMI};
	localparam logic [7:0] BLANK_CHARS [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VTAB, CH_FF,
		CH_CR};

	typedef enum int {
		READY_STEADY,
		READY_COIN,
		READY_SPARSE,
		READY_PERIODIC
	} ready_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           text_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [KIND_BITS-1:0] token_kind;
	logic [15:0]          token_line;
	logic [15:0]          token_column;
	logic [19:0]          token_offset;
	logic [LEN_BITS-1:0]  token_length;
	logic                 last_of_run;

	int failures;
	int outstanding;
	int quiet_cycles = 0;
	int burst_left = 0;
	int bytes_sent = 0;
	logic [7:0] text_q[$];

	ready_mode_t ready_mode = READY_STEADY;
	int ready_left = 0;
	int ready_tick = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	arithmetic_expression_tokenizer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_line   (token_line),
		.token_column (token_column),
		.token_offset (token_offset),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	arithmetic_expression_tokenizer_checker token_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_line   (token_line),
		.token_column (token_column),
		.token_offset (token_offset),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	// receiver stalls: phases of steady, coin-flip, sparse and periodic ready
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			ready_left <= $urandom_range(20, 300);
		end else begin
			ready_left <= ready_left - 1;
		end
		ready_tick <= ready_tick + 1;
		case (ready_mode)
			READY_STEADY:   out_ready <= 1'b1;
			READY_COIN:     out_ready <= $urandom_range(0, 1);
			READY_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
			default:        out_ready <= (ready_tick % 5) < 2;
		endcase
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] digit_char();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] ident_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return 8'(8'h41 + r);
		if (r < 52)
			return 8'(8'h61 + r - 26);
		if (r < 62)
			return 8'(8'h30 + r - 52);
		return CH_UNDER;
	endfunction

	// one request, then a random gap at the end of a burst
	task automatic send_byte(input logic [7:0] b);
		int gap_len;
		in_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap_len = $urandom_range(1, 14);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
			in_valid <= 1'b0;
			repeat (gap_len) @(posedge clk);
		end
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i]);
		text_q.delete();
	endtask

	// hold off requests until every predicted token has come out
	task automatic drain_tokens();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// add one character at the end of the text being built
	task automatic append_char(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	// random expression text, mostly well formed, usually ending in the terminator
	task automatic compose_text();
		int pieces;
		int pick;
		int len;
		pieces = $urandom_range(1, 12);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				len = $urandom_range(0, 52);
				append_char(len < 26 ? 8'(8'h41 + len) : len < 52 ? 8'(8'h61 + len - 26)
					: CH_UNDER);
				len = $urandom_range(0, 6);
				repeat (len) append_char(ident_char());
			end else if (pick < 45) begin
				len = $urandom_range(1, 5);
				repeat (len) append_char(digit_char());
			end else if (pick < 55) begin
				len = $urandom_range(1, 3);
				repeat (len) append_char(digit_char());
				append_char(CH_DOT);
				len = $urandom_range(0, 3);
				repeat (len) append_char(digit_char());
			end else if (pick < 75) begin
				append_char(PUNCT_CHARS[$urandom_range(0, 7)]);
			end else if (pick < 85) begin
				len = $urandom_range(1, 3);
				repeat (len) append_char(BLANK_CHARS[$urandom_range(0, 5)]);
			end else if (pick < 92) begin
				// lone dot, or a float broken by a second dot
				if ($urandom_range(0, 1) == 0) begin
					append_char(CH_DOT);
				end else begin
					append_char(digit_char());
					append_char(CH_DOT);
					append_char(digit_char());
					append_char(CH_DOT);
				end
			end else begin
				append_char(8'($urandom_range(0, 255)));
			end

			pick = $urandom_range(0, 99);
			if (pick < 40)
				append_char(CH_SPACE);
			else if (pick < 55)
				append_char(CH_NL);
		end
		if ($urandom_range(0, 9) != 0)
			append_char(CH_NUL);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every kind, dot cases, blanks, high bytes, close plus end
		text_q = '{CH_UNDER, "a", "Z", "9", CH_PLUS, "0", CH_DOT, "5", CH_DOT, CH_DOT,
			"8", CH_DOT, CH_TAB, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUALS, CH_LPAREN,
			CH_RPAREN, CH_SEMI, CH_NL, CH_VTAB, CH_FF, CH_CR, 8'h80, 8'hFF, "7", CH_NUL};
		send_text();
		drain_tokens();

		// random texts
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			compose_text();
			send_text();
			if ($urandom_range(0, 9) == 0)
				drain_tokens();
		end
		send_byte(CH_NUL);
		drain_tokens();
		repeat (10) @(posedge clk);

		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/aet_pkg.sv
src/arithmetic_expression_tokenizer_top.sv
bench/arithmetic_expression_tokenizer_checker.sv
bench/arithmetic_expression_tokenizer_top_test.sv
